// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the histogram RTL.
// Needs a clock and an active-high synchronous reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define WLH_ASSERT_IMP(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("wlh: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define WLH_ASSERT_NXT(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("wlh: next-cycle check failed");

`endif

// ===== rtl/core/wlh_pkg.sv =====
// Shared types and constants of the word length histogram.
// No dependencies; used by the interfaces, the result queue and the top level.
package wlh_pkg;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 6;
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 32;
  localparam int LETTERS  = 26;

  localparam logic [FUNC_W-1:0] FN_BYTE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FLUSH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  // result queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 2;

  typedef struct packed {
    logic                word_done;
    logic [LEN_W-1:0]    word_length;
    logic [LETTER_W-1:0] word_letter;
    logic                long_word;
    logic                bad_initial;
    logic [COUNT_W-1:0]  read_count;
  } out_t;

endpackage

// ===== rtl/core/wlh_in_if.sv =====
// Request channel of the word length histogram: valid/ready plus item fields.
// Depends on wlh_pkg for field widths.
interface wlh_in_if;
  logic                          valid;
  logic                          ready;
  logic [wlh_pkg::FUNC_W-1:0]    func;
  logic [wlh_pkg::BYTE_W-1:0]    in_byte;
  logic [wlh_pkg::LEN_W-1:0]     bin_length;
  logic [wlh_pkg::LETTER_W-1:0]  bin_letter;

  modport source (output valid, func, in_byte, bin_length, bin_letter, input ready);
  modport sink   (input valid, func, in_byte, bin_length, bin_letter, output ready);
endinterface

// ===== rtl/core/wlh_out_if.sv =====
// Result channel of the word length histogram: valid/ready plus result fields.
// Depends on wlh_pkg for field widths.
interface wlh_out_if;
  logic                          valid;
  logic                          ready;
  logic                          word_done;
  logic [wlh_pkg::LEN_W-1:0]     word_length;
  logic [wlh_pkg::LETTER_W-1:0]  word_letter;
  logic                          long_word;
  logic                          bad_initial;
  logic [wlh_pkg::COUNT_W-1:0]   read_count;

  modport source (output valid, word_done, word_length, word_letter, long_word,
                  bad_initial, read_count, input ready);
  modport sink   (input valid, word_done, word_length, word_letter, long_word,
                  bad_initial, read_count, output ready);
endinterface

// ===== rtl/core/wlh_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module wlh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same entry is written on this edge
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/wlh_oq.sv =====
// Three-entry result queue that drives the result channel.
// Depends on wlh_pkg, wlh_out_if and assert_macros.svh.
`include "assert_macros.svh"

module wlh_oq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  wlh_pkg::out_t                  push_data,
  output logic [wlh_pkg::OQ_CNT_W-1:0]   count,
  wlh_out_if.source                      rsp
);

  wlh_pkg::out_t                 entries [wlh_pkg::OQ_DEPTH];
  logic [wlh_pkg::OQ_PTR_W-1:0]  wr_ptr;
  logic [wlh_pkg::OQ_PTR_W-1:0]  rd_ptr;
  logic                          pop;
  wlh_pkg::out_t                 head;

  localparam logic [wlh_pkg::OQ_PTR_W-1:0] LAST_PTR =
    wlh_pkg::OQ_PTR_W'(wlh_pkg::OQ_DEPTH - 1);

  assign pop  = rsp.valid && rsp.ready;
  assign head = entries[rd_ptr];

  assign rsp.valid       = (count != '0);
  assign rsp.word_done   = head.word_done;
  assign rsp.word_length = head.word_length;
  assign rsp.word_letter = head.word_letter;
  assign rsp.long_word   = head.long_word;
  assign rsp.bad_initial = head.bad_initial;
  assign rsp.read_count  = head.read_count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `WLH_ASSERT_IMP(a_no_overflow, clk, rst, push && !pop,
                  count != wlh_pkg::OQ_CNT_W'(wlh_pkg::OQ_DEPTH))
  `WLH_ASSERT_NXT(a_push_shows, clk, rst, push, rsp.valid)

endmodule

// ===== rtl/core/word_length_initial_histogram.sv =====
// Top level of the word length / initial letter histogram.
// Depends on wlh_pkg, wlh_in_if, wlh_out_if, wlh_ram, wlh_oq, assert_macros.svh.
//
//   channel | dir | fields
//   req     | in  | func, in_byte, bin_length, bin_letter
//   rsp     | out | word_done, word_length, word_letter, long_word, bad_initial,
//           |     | read_count
//
// One request per cycle while req.ready is high; its result is registered in s1, then
// enters the result queue and can leave on rsp from there.
// Counters sit in one RAM (row = length - 1, column = letter); an update reads
// on acceptance and writes back from the s1 stage, forwarding the last write.
// After reset a clearing pass over all MAX_LEN * 32 entries (1024 by default) zeroes
// the RAM; req.ready is low during it.
// req.ready depends only on registers: it drops when the three-entry result
// queue could not absorb the requests in flight.
`include "assert_macros.svh"

module word_length_initial_histogram #(
  parameter int MAX_LEN = 32
) (
  input  logic      clk,
  input  logic      rst,
  wlh_in_if.sink    req,
  wlh_out_if.source rsp
);

  localparam int ROW_W  = $clog2(MAX_LEN);
  localparam int ADDR_W = ROW_W + wlh_pkg::LETTER_W;
  localparam int DEPTH  = MAX_LEN * (1 << wlh_pkg::LETTER_W);
  localparam int RUN_W  = $clog2(MAX_LEN + 2);
  localparam int CLR_W  = $clog2(DEPTH);

  localparam logic [wlh_pkg::BYTE_W-1:0] CH_UP_A = 8'h41;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_LO_A = 8'h61;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_LO_Z = 8'h7A;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_AE_LO = 8'hE4;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_OE_LO = 8'hF6;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_AE_UP = 8'hC4;
  localparam logic [wlh_pkg::BYTE_W-1:0] CH_OE_UP = 8'hD6;

  typedef struct packed {
    logic                upd;
    logic                rd_ok;
    logic [ADDR_W-1:0]   addr;
    wlh_pkg::out_t       res;
  } s1_t;

  // run state
  logic [RUN_W-1:0]             run_length, run_length_next;
  logic [wlh_pkg::LETTER_W-1:0] run_letter, run_letter_next;
  logic                         run_initial_bad, run_initial_bad_next;
  logic                         in_word, in_word_next;

  // front stage
  logic                         accept;
  logic                         is_plain;
  logic                         is_umlaut;
  logic                         ending;
  logic                         is_long;
  logic [RUN_W-1:0]             clamped_len;
  logic                         upd;
  logic                         rd_ok;
  logic [ROW_W-1:0]             upd_row;
  logic [ROW_W-1:0]             rd_row;
  logic [ADDR_W-1:0]            raddr;
  s1_t                          s1_next;

  // write-back stage
  logic                         s1_valid;
  s1_t                          s1;
  logic [wlh_pkg::COUNT_W-1:0]  ram_rdata;
  logic [wlh_pkg::COUNT_W-1:0]  cur;
  logic [wlh_pkg::COUNT_W-1:0]  inc;
  logic                         upd_we;
  logic                         last_wr_valid;
  logic [ADDR_W-1:0]            last_wr_addr;
  logic [wlh_pkg::COUNT_W-1:0]  last_wr_data;
  wlh_pkg::out_t                push_data;

  // clearing pass
  logic                         clear_busy;
  logic [CLR_W-1:0]             clear_addr;

  // RAM write port
  logic                         ram_we;
  logic [CLR_W-1:0]             ram_waddr;
  logic [wlh_pkg::COUNT_W-1:0]  ram_wdata;

  logic [wlh_pkg::OQ_CNT_W-1:0] q_count;

  assign req.ready = !clear_busy &&
    ((3'(q_count) + 3'(s1_valid)) < 3'(wlh_pkg::OQ_DEPTH));
  assign accept = req.valid && req.ready;

  always_comb begin
    is_plain  = (req.in_byte inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]});
    is_umlaut = (req.in_byte inside {CH_AE_LO, CH_OE_LO, CH_AE_UP, CH_OE_UP});
    ending    = in_word && (((req.func == wlh_pkg::FN_BYTE) && !is_plain && !is_umlaut) ||
                            (req.func == wlh_pkg::FN_FLUSH));
    is_long     = (run_length > RUN_W'(MAX_LEN));
    clamped_len = is_long ? RUN_W'(MAX_LEN) : run_length;
    upd         = ending && !run_initial_bad;
    upd_row     = ROW_W'(clamped_len - RUN_W'(1));
    rd_ok       = (req.func == wlh_pkg::FN_READ) && (req.bin_length != '0) &&
                  (req.bin_length <= wlh_pkg::LEN_W'(MAX_LEN)) &&
                  (req.bin_letter < wlh_pkg::LETTER_W'(wlh_pkg::LETTERS));
    rd_row      = ROW_W'(req.bin_length - wlh_pkg::LEN_W'(1));
    raddr       = upd ? {upd_row, run_letter} : {rd_row, req.bin_letter};
  end

  always_comb begin
    s1_next                 = '0;
    s1_next.upd             = upd;
    s1_next.rd_ok           = rd_ok;
    s1_next.addr            = raddr;
    s1_next.res.word_done   = upd;
    s1_next.res.word_length = ending ? wlh_pkg::LEN_W'(clamped_len) : '0;
    s1_next.res.word_letter = upd ? run_letter : '0;
    s1_next.res.long_word   = ending && is_long;
    s1_next.res.bad_initial = ending && run_initial_bad;
  end

  always_comb begin
    run_length_next      = run_length;
    run_letter_next      = run_letter;
    run_initial_bad_next = run_initial_bad;
    in_word_next         = in_word;
    if (ending) begin
      run_length_next      = '0;
      run_letter_next      = '0;
      run_initial_bad_next = 1'b0;
      in_word_next         = 1'b0;
    end else if ((req.func == wlh_pkg::FN_BYTE) && (is_plain || is_umlaut)) begin
      if (!in_word) begin
        in_word_next         = 1'b1;
        run_length_next      = RUN_W'(1);
        run_initial_bad_next = is_umlaut;
        // low five bits of a letter are its alphabet position plus one
        run_letter_next      = is_umlaut ? '0 : req.in_byte[4:0] - 5'd1;
      end else if (run_length <= RUN_W'(MAX_LEN)) begin
        run_length_next = run_length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length      <= '0;
      run_letter      <= '0;
      run_initial_bad <= 1'b0;
      in_word         <= 1'b0;
      s1_valid        <= 1'b0;
      last_wr_valid   <= 1'b0;
      clear_busy      <= 1'b1;
      clear_addr      <= '0;
    end else begin
      if (accept) begin
        run_length      <= run_length_next;
        run_letter      <= run_letter_next;
        run_initial_bad <= run_initial_bad_next;
        in_word         <= in_word_next;
      end
      s1_valid      <= accept;
      last_wr_valid <= upd_we;
      if (clear_busy) begin
        if (clear_addr == CLR_W'(DEPTH - 1)) begin
          clear_busy <= 1'b0;
        end else begin
          clear_addr <= clear_addr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (upd_we) begin
      last_wr_addr <= s1.addr;
      last_wr_data <= inc;
    end
  end

  // take the value written on the edge that issued this read
  always_comb begin
    cur = (last_wr_valid && (last_wr_addr == s1.addr)) ? last_wr_data : ram_rdata;
    inc = (&cur) ? cur : cur + 1'b1;
    upd_we = s1_valid && s1.upd;
    push_data = s1.res;
    push_data.read_count = s1.rd_ok ? cur : '0;
  end

  always_comb begin
    ram_we    = clear_busy || upd_we;
    ram_waddr = clear_busy ? clear_addr : CLR_W'(s1.addr);
    ram_wdata = clear_busy ? '0 : inc;
  end

  wlh_ram #(
    .WIDTH (wlh_pkg::COUNT_W),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && (upd || rd_ok)),
    .raddr (CLR_W'(raddr)),
    .rdata (ram_rdata)
  );

  wlh_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (push_data),
    .count     (q_count),
    .rsp       (rsp)
  );

  `WLH_ASSERT_NXT(a_accept_to_s1, clk, rst, accept, s1_valid)
  `WLH_ASSERT_IMP(a_clear_idle, clk, rst, clear_busy, !s1_valid && !accept)
  `WLH_ASSERT_IMP(a_upd_len, clk, rst, upd_we, s1.res.word_length != '0)
  `WLH_ASSERT_IMP(a_no_wrap, clk, rst, upd_we, inc != '0)

endmodule
